### hw/rtl/plh_pkg.sv
// ----------------------------------------------------------------------------
// plh_pkg: shared types and constants for the packet latency histogram
// Holds the mode and state codes, register indexes and bucket thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package plh_pkg;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_LAT,
    S_BKT,
    S_RD,
    S_WR,
    S_QTGT,
    S_QWALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic ram_re;
    logic ram_we;
    logic walk_first;
    logic out_load;
  } ctrl_t;

  localparam logic CFG_NS_PER_CYCLE = 1'b0;
  localparam logic CFG_MIN_BYTES    = 1'b1;

  localparam logic [15:0] NS_PER_CYCLE_RESET = 16'd17246;
  localparam logic [7:0]  MIN_BYTES_RESET    = 8'd16;

  localparam logic [63:0] NS_PER_US = 64'd1000;

  // Smallest latency in ns that puts a packet above bucket k.
  function automatic logic [63:0] bucket_floor(input int k);
    return ((64'd1 << k) + 64'd1) * NS_PER_US;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/plh_ram.sv
// ----------------------------------------------------------------------------
// plh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/packet_latency_histogram.sv
// ----------------------------------------------------------------------------
// packet_latency_histogram: packet latency monitor with log2 histogram
// Records packet latencies, answers percentile queries and clears intervals.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A record item passes through the two
// multiplies and the bucket read-modify-write through the single bucket RAM
// before the next accept. A query reads the RAM once per bucket it walks,
// stopping at the first hit or at the last bucket. Clear, short and
// unused-mode items go straight to completion. Synchronous reset zeroes
// all statistics at once; the bucket RAM is masked by per-entry valid bits.
`default_nettype none

module packet_latency_histogram #(
  parameter int BUCKETS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_send_timestamp,
  input  wire logic [63:0] in_arrival_time,
  input  wire logic [63:0] in_sequence_req,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [16:0] in_percentile_q16,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic [63:0]      out_latency_ns,
  output logic [3:0]       out_bucket_index,
  output logic [41:0]      out_percentile_ns,
  output logic [31:0]      out_packet_count,
  output logic [63:0]      out_total_latency_ns,
  output logic [63:0]      out_max_latency_ns,
  output logic [63:0]      out_lost_total
);

  localparam int AW = $clog2(BUCKETS);
  localparam int CW = 32 + $clog2(BUCKETS + 1);

  plh_pkg::state_t state_r, state_nxt;
  plh_pkg::ctrl_t  ctrl;

  logic [15:0] ns_per_cycle_r;
  logic [7:0]  min_bytes_r;

  logic [31:0] cnt_r;
  logic [63:0] sum_r;
  logic [63:0] peak_r;
  logic [63:0] next_seq_r;
  logic [63:0] lost_r;
  logic [BUCKETS-1:0] bvalid_r;

  logic [63:0] diff_r;
  logic [63:0] gap_r;
  logic [63:0] seq_r;
  logic [16:0] frac_r;
  logic        rec_ok_r;
  logic        query_r;
  logic [47:0] p0_r;
  logic [47:0] p1_r;
  logic [63:0] lat_r;
  logic [AW-1:0] bkt_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] cum_r;
  logic [32:0]   target_r;
  logic [41:0]   pct_r;

  logic          accept;
  logic          is_rec, is_query, is_clear, long_enough;
  logic [AW-1:0] bkt_pick;
  logic [31:0]   bucket_now;
  logic [31:0]   bucket_inc;
  logic [CW-1:0] cum_nxt;
  logic          walk_hit, walk_last;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic [64:0]   sum_add, lost_add;
  logic [48:0]   target_full;

  logic out_valid_r;

  assign accept      = in_valid && in_ready;
  assign is_rec      = in_mode == plh_pkg::MODE_RECORD;
  assign is_query    = in_mode == plh_pkg::MODE_QUERY;
  assign is_clear    = in_mode == plh_pkg::MODE_CLEAR;
  assign long_enough = in_packet_length >= {8'd0, min_bytes_r};

  // Bucket choice: count the thresholds the latency reaches.
  always_comb begin
    bkt_pick = '0;
    for (int k = 0; k < BUCKETS - 1; k++) begin
      if (lat_r >= plh_pkg::bucket_floor(k)) begin
        bkt_pick = AW'(k + 1);
      end
    end
  end

  assign bucket_now  = bvalid_r[bkt_r] ? ram_rdata : 32'd0;
  assign bucket_inc  = (bucket_now == 32'hFFFF_FFFF) ? bucket_now : bucket_now + 32'd1;
  assign cum_nxt     = cum_r + CW'(bvalid_r[idx_r] ? ram_rdata : 32'd0);
  assign walk_hit    = cum_nxt >= CW'(target_r);
  assign walk_last   = idx_r == AW'(BUCKETS - 1);
  assign sum_add     = {1'b0, sum_r} + {1'b0, lat_r};
  assign lost_add    = {1'b0, lost_r} + {1'b0, gap_r};
  assign target_full = cnt_r * frac_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plh_pkg::S_IDLE: begin
        if (accept) begin
          if (is_rec && long_enough) begin
            state_nxt = plh_pkg::S_MUL;
          end else if (is_query) begin
            state_nxt = plh_pkg::S_QTGT;
          end else begin
            state_nxt = plh_pkg::S_DONE;
          end
        end
      end
      plh_pkg::S_MUL:  state_nxt = plh_pkg::S_LAT;
      plh_pkg::S_LAT:  state_nxt = plh_pkg::S_BKT;
      plh_pkg::S_BKT:  state_nxt = plh_pkg::S_RD;
      plh_pkg::S_RD:   state_nxt = plh_pkg::S_WR;
      plh_pkg::S_WR:   state_nxt = plh_pkg::S_DONE;
      plh_pkg::S_QTGT: state_nxt = plh_pkg::S_QWALK;
      plh_pkg::S_QWALK: begin
        if (walk_hit || walk_last) begin
          state_nxt = plh_pkg::S_DONE;
        end
      end
      plh_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = plh_pkg::S_IDLE;
        end
      end
      default: state_nxt = plh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      plh_pkg::S_IDLE: ctrl.in_ready = 1'b1;
      plh_pkg::S_RD:   ctrl.ram_re = 1'b1;
      plh_pkg::S_WR:   ctrl.ram_we = 1'b1;
      plh_pkg::S_QTGT: begin
        ctrl.ram_re     = 1'b1;
        ctrl.walk_first = 1'b1;
      end
      plh_pkg::S_QWALK: ctrl.ram_re = !(walk_hit || walk_last);
      plh_pkg::S_DONE:  ctrl.out_load = !out_valid_r || out_ready;
      default: ctrl = '0;
    endcase
  end

  assign in_ready = ctrl.in_ready;

  always_comb begin
    if (ctrl.walk_first) begin
      ram_raddr = '0;
    end else if (state_r == plh_pkg::S_QWALK) begin
      ram_raddr = idx_r + AW'(1);
    end else begin
      ram_raddr = bkt_r;
    end
  end

  plh_ram #(
    .WIDTH(32),
    .DEPTH(BUCKETS)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (ctrl.ram_we),
    .waddr(bkt_r),
    .wdata(bucket_inc),
    .re   (ctrl.ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plh_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_per_cycle_r <= plh_pkg::NS_PER_CYCLE_RESET;
      min_bytes_r    <= plh_pkg::MIN_BYTES_RESET;
    end else if (cfg_we) begin
      if (cfg_index == plh_pkg::CFG_NS_PER_CYCLE) begin
        ns_per_cycle_r <= cfg_wdata;
      end else begin
        min_bytes_r <= cfg_wdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      peak_r     <= '0;
      next_seq_r <= '0;
      lost_r     <= '0;
      bvalid_r   <= '0;
    end else begin
      if (accept && is_clear) begin
        cnt_r    <= '0;
        sum_r    <= '0;
        peak_r   <= '0;
        bvalid_r <= '0;
      end
      if (state_r == plh_pkg::S_LAT) begin
        next_seq_r <= seq_r + 64'd1;
        lost_r     <= lost_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : lost_add[63:0];
      end
      if (state_r == plh_pkg::S_BKT) begin
        if (cnt_r != 32'hFFFF_FFFF) begin
          cnt_r <= cnt_r + 32'd1;
        end
        sum_r <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
        if (lat_r > peak_r) begin
          peak_r <= lat_r;
        end
      end
      if (ctrl.ram_we) begin
        bvalid_r[bkt_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r   <= in_arrival_time - in_send_timestamp;
      gap_r    <= in_sequence_req - next_seq_r;
      seq_r    <= in_sequence_req;
      frac_r   <= in_percentile_q16;
      rec_ok_r <= is_rec && long_enough;
      query_r  <= is_query;
    end
    if (state_r == plh_pkg::S_MUL) begin
      p0_r <= diff_r[31:0] * ns_per_cycle_r;
      p1_r <= diff_r[63:32] * ns_per_cycle_r;
    end
    if (state_r == plh_pkg::S_LAT) begin
      lat_r <= {32'd0, p0_r[47:16]} + {p1_r, 16'd0};
    end
    if (state_r == plh_pkg::S_BKT) begin
      bkt_r <= bkt_pick;
    end
    if (ctrl.walk_first) begin
      target_r <= target_full[48:16];
      idx_r    <= '0;
      cum_r    <= '0;
    end
    if (state_r == plh_pkg::S_QWALK) begin
      cum_r <= cum_nxt;
      if (walk_hit) begin
        pct_r <= 42'(plh_pkg::NS_PER_US) << idx_r;
      end else if (walk_last) begin
        pct_r <= 42'(plh_pkg::NS_PER_US) << BUCKETS;
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_accepted         <= rec_ok_r;
      out_latency_ns       <= rec_ok_r ? lat_r : 64'd0;
      out_bucket_index     <= rec_ok_r ? 4'(bkt_r) : 4'd0;
      out_percentile_ns    <= query_r ? pct_r : 42'd0;
      out_packet_count     <= cnt_r;
      out_total_latency_ns <= sum_r;
      out_max_latency_ns   <= peak_r;
      out_lost_total       <= lost_r;
    end
  end

  assign out_valid = out_valid_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == plh_pkg::S_DONE))
    else $error("result appeared outside the completion state");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && is_clear) |=> cnt_r >= $past(cnt_r))
    else $error("packet count dropped without a clear item");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == plh_pkg::S_QWALK |-> idx_r <= AW'(BUCKETS - 1))
    else $error("percentile walk ran past the last bucket");

  a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ram_we |-> $past(state_r == plh_pkg::S_RD) && rec_ok_r)
    else $error("bucket write without a recorded packet");

endmodule

`default_nettype wire
